@@ rtl/core/lidar_point_range_filter_top_defines.svh @@
// ----------------------------------------------------------------------------
// Lidar point range filter assertion macros
// Shared concurrent assertion forms for the checker of the point filter.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_RANGE_FILTER_TOP_DEFINES_SVH
`define LIDAR_POINT_RANGE_FILTER_TOP_DEFINES_SVH

// Checked on every rising edge of clk while reset is released.
`define LPRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define LPRF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lprf_pkg.sv @@
// ----------------------------------------------------------------------------
// Lidar point range filter package
// Shared widths, register indexes, mode codes and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lprf_pkg;

	// Default coordinate width in bits.
	localparam int COORD_BITS_DEF = 20;

	// Bits of the fixed-width fields in an input and an output beat.
	localparam int IN_FIXED_BITS  = 64;
	localparam int OUT_FIXED_BITS = 76;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_ADDR_W-1:0] REG_LIDAR_MODE   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LINE_COUNT   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DECIMATION   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE_MM = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE_MM = 3'd4;

	// Register reset values.
	localparam logic [7:0]  LINE_COUNT_RST = 8'd6;
	localparam logic [15:0] DECIMATION_RST = 16'd1;
	localparam logic [18:0] MIN_RANGE_RST  = 19'd0;
	localparam logic [18:0] MAX_RANGE_RST  = 19'h7FFFF;

	// Sensor modes.
	localparam logic [1:0] MODE_PACKET  = 2'd0;
	localparam logic [1:0] MODE_SPIN_US = 2'd1;
	localparam logic [1:0] MODE_SPIN_NS = 2'd2;

	// Packet-mode tag check: bits 5:4 must read 00 or 01.
	localparam logic [7:0] TAG_FIELD_MASK = 8'h30;
	localparam logic [7:0] TAG_OK_SINGLE  = 8'h10;
	localparam logic [7:0] TAG_OK_NONE    = 8'h00;

	// Range output.
	localparam int         RANGE_W   = 20;
	localparam logic [19:0] RANGE_MAX = 20'hFFFFF;

	// Nanosecond to microsecond conversion, radix-4 long division.
	localparam int NS_PER_US = 1000;
	localparam int NS_HALF   = 500;
	localparam int TIME_W    = 32;
	localparam int DIV_DW    = 34;
	localparam int DIV_STEPS = DIV_DW / 2;
	localparam int DIV_REM_W = 10;
	localparam int DIV_SH_W  = DIV_REM_W + 2;

endpackage

@@ rtl/core/lidar_point_range_filter_top.sv @@
// ----------------------------------------------------------------------------
// Lidar point range filter
// Range window, line, tag and decimation filter for one lidar point a beat.
// ----------------------------------------------------------------------------
// The input stream carries one point per beat; the output stream carries the
// points that survive the filter, each with its time in microseconds and, in
// the spinning modes, its integer range. Dropped points produce no beat.
// Registers are written through the cfg port and must only change while the
// block is idle.
// Each point is accepted, then the squares of its x, y and z are formed on
// a shared multiplier and summed into the squared range, then a bit-serial
// square root retires one result bit per cycle, and a last step decides and
// writes the result. The radix-4 time division runs beside the square root.
// Reset clears the registers to their defaults, the previous point to zero
// and the scan index to zero, and empties the output register.
// When the receiver stalls, the finished beat waits in the output register
// while the next point is accepted and worked on; the block only holds its
// next decision until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lidar_point_range_filter_top #(
	parameter int COORD_BITS = lprf_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// Point input. tdata from bit 0: pos_x, pos_y, pos_z, reflect, ring_in,
	// tag_in, raw_time, zero padding.
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((3 * COORD_BITS + lprf_pkg::IN_FIXED_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// tuser from bit 0: is_number, scan_start.
	input  logic [1:0] s_axis_tuser,

	// Result output. tdata from bit 0: out_x, out_y, out_z, out_intensity,
	// out_ring, out_time_us, out_range_mm, zero padding.
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((3 * COORD_BITS + lprf_pkg::OUT_FIXED_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,

	// Register write port.
	input  logic                            cfg_we,
	input  logic [lprf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [lprf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lprf_pkg::*;

	localparam int CB        = COORD_BITS;
	localparam int OUT_DW    = ((3 * CB + OUT_FIXED_BITS + 7) / 8) * 8;
	localparam int SQW       = 2 * CB;
	localparam int RMW       = CB + 3;
	localparam int CMPW      = (CB > CFG_DATA_W) ? CB : CFG_DATA_W;
	localparam int RTW       = (CB > RANGE_W) ? CB : RANGE_W;
	localparam int SQR_STEPS = 4;
	localparam int LAST_STEP = SQR_STEPS + CB;
	localparam int CNT_W     = $clog2(LAST_STEP + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;

	// Configuration registers.
	logic [1:0]         mode_q;
	logic [7:0]         line_count_q;
	logic [15:0]        decim_q;
	logic [18:0]        min_range_q;
	logic [18:0]        max_range_q;

	// State kept from point to point.
	logic [CB-1:0]      last_x_q, last_y_q, last_z_q;
	logic [15:0]        phase_q;
	logic               seen_first_q;

	// The point being worked on.
	logic [CB-1:0]      x_q, y_q, z_q;
	logic [CB-1:0]      mag_x_q, mag_y_q, mag_z_q;
	logic [15:0]        refl_q;
	logic [7:0]         ring_q, tag_q;
	logic [TIME_W-1:0]  time_q;
	logic               num_q, start_q;

	// Arithmetic state.
	logic [SQW-1:0]     prod_q, acc_q;
	logic [RMW-1:0]     rem_q;
	logic [CB-1:0]      root_q;
	logic               differs_q;
	logic [DIV_DW-1:0]  div_n_q;
	logic [DIV_REM_W-1:0] div_r_q;
	logic [TIME_W-1:0]  div_quo_q;

	// Output register.
	logic               out_valid_q;
	logic [OUT_DW-1:0]  out_data_q;

	// Input field views.
	logic [CB-1:0]      in_x, in_y, in_z;
	logic [CB-1:0]      in_mag_x, in_mag_y, in_mag_z;
	logic               in_fire;

	// Step helpers.
	logic [CB-1:0]      sq_op;
	logic [RMW-1:0]     rem_sh, trial;
	logic               take;
	logic [DIV_SH_W-1:0] div_sh;
	logic [DIV_SH_W-1:0] div_rem_nx;
	logic [1:0]         div_digit;

	// Decision helpers.
	logic [15:0]        phase_cur, dec_eff, phase_adv, phase_nx;
	logic [16:0]        phase_inc;
	logic [CMPW-1:0]    root_c, min_c, max_c;
	logic [RTW-1:0]     root_x;
	logic               rem_zero, gt_lo, lt_hi, ge_lo, le_hi, first, tag_ok;
	logic               counted, keep, emit_go;
	logic [7:0]         o_ring;
	logic [TIME_W-1:0]  o_time;
	logic [RANGE_W-1:0] o_range, range_sat;

	assign in_x = s_axis_tdata[0 +: CB];
	assign in_y = s_axis_tdata[CB +: CB];
	assign in_z = s_axis_tdata[2 * CB +: CB];

	// Two's complement magnitudes; the most negative value maps to 2^(CB-1).
	assign in_mag_x = in_x[CB-1] ? (~in_x + CB'(1)) : in_x;
	assign in_mag_y = in_y[CB-1] ? (~in_y + CB'(1)) : in_y;
	assign in_mag_z = in_z[CB-1] ? (~in_z + CB'(1)) : in_z;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign emit_go       = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Operand of the shared squaring multiplier.
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_op = mag_x_q;
			2'd1:    sq_op = mag_y_q;
			default: sq_op = mag_z_q;
		endcase
	end

	// One square-root digit: bring down the next two radicand bits and try
	// four times the partial root plus one.
	assign rem_sh = {rem_q[RMW-3:0], acc_q[SQW-1 -: 2]};
	assign trial  = RMW'({root_q, 2'b01});
	assign take   = (rem_sh >= trial);

	// One radix-4 quotient digit of the time division by 1000.
	assign div_sh = {div_r_q, div_n_q[DIV_DW-1 -: 2]};
	always_comb begin
		if (div_sh >= DIV_SH_W'(3 * NS_PER_US)) begin
			div_digit  = 2'd3;
			div_rem_nx = div_sh - DIV_SH_W'(3 * NS_PER_US);
		end else if (div_sh >= DIV_SH_W'(2 * NS_PER_US)) begin
			div_digit  = 2'd2;
			div_rem_nx = div_sh - DIV_SH_W'(2 * NS_PER_US);
		end else if (div_sh >= DIV_SH_W'(NS_PER_US)) begin
			div_digit  = 2'd1;
			div_rem_nx = div_sh - DIV_SH_W'(NS_PER_US);
		end else begin
			div_digit  = 2'd0;
			div_rem_nx = div_sh;
		end
	end

	// Scan index: a start of scan forces phase zero, a decimation of zero
	// acts as one, and the phase wraps once it reaches the decimation.
	assign phase_cur = start_q ? 16'd0 : phase_q;
	assign dec_eff   = (decim_q == 16'd0) ? 16'd1 : decim_q;
	assign phase_inc = {1'b0, phase_cur} + 17'd1;
	assign phase_adv = (phase_inc >= {1'b0, dec_eff}) ? 16'd0 : phase_inc[15:0];

	// Window tests. The squared range is root^2 + rem, so comparing against
	// a squared integer bound needs only the root and whether rem is zero.
	assign root_c   = CMPW'(root_q);
	assign min_c    = CMPW'(min_range_q);
	assign max_c    = CMPW'(max_range_q);
	assign rem_zero = (rem_q == '0);
	assign gt_lo    = (root_c > min_c) || ((root_c == min_c) && !rem_zero);
	assign lt_hi    = (root_c < max_c);
	assign ge_lo    = (root_c >= min_c);
	assign le_hi    = lt_hi || ((root_c == max_c) && rem_zero);

	assign root_x    = RTW'(root_q);
	assign range_sat = (root_x > RTW'(RANGE_MAX)) ? RANGE_MAX : root_x[RANGE_W-1:0];

	assign first  = start_q || !seen_first_q;
	assign tag_ok = ((tag_q & TAG_FIELD_MASK) == TAG_OK_SINGLE) ||
		((tag_q & TAG_FIELD_MASK) == TAG_OK_NONE);

	always_comb begin
		counted = 1'b0;
		keep    = 1'b0;
		o_ring  = 8'd0;
		o_time  = '0;
		o_range = '0;
		case (mode_q)
			MODE_PACKET: begin
				counted = 1'b1;
				keep    = !first && (ring_q < line_count_q) && tag_ok &&
					(phase_cur == 16'd0) && differs_q && gt_lo && lt_hi;
				o_time  = div_quo_q;
			end
			MODE_SPIN_US, MODE_SPIN_NS: begin
				counted = num_q;
				keep    = num_q && (phase_cur == 16'd0) && ge_lo && le_hi;
				o_ring  = ring_q;
				o_time  = (mode_q == MODE_SPIN_US) ? time_q : div_quo_q;
				o_range = range_sat;
			end
			default: begin
				counted = 1'b0;
				keep    = 1'b0;
			end
		endcase
	end

	assign phase_nx = counted ? phase_adv : phase_cur;

	// Control, configuration and carried state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			mode_q       <= MODE_PACKET;
			line_count_q <= LINE_COUNT_RST;
			decim_q      <= DECIMATION_RST;
			min_range_q  <= MIN_RANGE_RST;
			max_range_q  <= MAX_RANGE_RST;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_z_q     <= '0;
			phase_q      <= '0;
			seen_first_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_LIDAR_MODE:   mode_q       <= cfg_wdata[1:0];
					REG_LINE_COUNT:   line_count_q <= cfg_wdata[7:0];
					REG_DECIMATION:   decim_q      <= cfg_wdata[15:0];
					REG_MIN_RANGE_MM: min_range_q  <= cfg_wdata;
					REG_MAX_RANGE_MM: max_range_q  <= cfg_wdata;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CALC;
						cnt_q   <= '0;
					end
				end
				ST_CALC: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(LAST_STEP - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q      <= ST_IDLE;
						last_x_q     <= x_q;
						last_y_q     <= y_q;
						last_z_q     <= z_q;
						phase_q      <= phase_nx;
						seen_first_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit_go && keep) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: point capture, squaring, square root, division and result.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q       <= in_x;
			y_q       <= in_y;
			z_q       <= in_z;
			mag_x_q   <= in_mag_x;
			mag_y_q   <= in_mag_y;
			mag_z_q   <= in_mag_z;
			refl_q    <= s_axis_tdata[3 * CB +: 16];
			ring_q    <= s_axis_tdata[3 * CB + 16 +: 8];
			tag_q     <= s_axis_tdata[3 * CB + 24 +: 8];
			time_q    <= s_axis_tdata[3 * CB + 32 +: TIME_W];
			num_q     <= s_axis_tuser[0];
			start_q   <= s_axis_tuser[1];
			div_n_q   <= DIV_DW'(s_axis_tdata[3 * CB + 32 +: TIME_W]) + DIV_DW'(NS_HALF);
			div_r_q   <= '0;
			div_quo_q <= '0;
		end

		if (state_q == ST_CALC) begin
			// Squares leave the multiplier in steps 0 to 2 and are summed one
			// step later, so the sum is complete at the end of step 3.
			if (cnt_q < CNT_W'(3)) begin
				prod_q <= sq_op * sq_op;
			end
			if (cnt_q == CNT_W'(0)) begin
				differs_q <= (x_q != last_x_q) || (y_q != last_y_q) || (z_q != last_z_q);
			end
			if (cnt_q == CNT_W'(1)) begin
				acc_q <= prod_q;
			end else if ((cnt_q == CNT_W'(2)) || (cnt_q == CNT_W'(3))) begin
				acc_q <= acc_q + prod_q;
			end else begin
				acc_q <= acc_q << 2;
			end
			if (cnt_q == CNT_W'(3)) begin
				rem_q  <= '0;
				root_q <= '0;
			end else if (cnt_q >= CNT_W'(SQR_STEPS)) begin
				rem_q  <= take ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[CB-2:0], take};
			end

			if (cnt_q < CNT_W'(DIV_STEPS)) begin
				div_n_q   <= div_n_q << 2;
				div_r_q   <= div_rem_nx[DIV_REM_W-1:0];
				div_quo_q <= {div_quo_q[TIME_W-3:0], div_digit};
			end
		end

		if (emit_go && keep) begin
			out_data_q <= OUT_DW'({o_range, o_time, o_ring, refl_q, z_q, y_q, x_q});
		end
	end

endmodule

@@ rtl/core/lprf_checker.sv @@
// ----------------------------------------------------------------------------
// Lidar point range filter checker
// Port-level assertions on the point filter, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lidar_point_range_filter_top_defines.svh"

module lprf_checker #(
	parameter int COORD_BITS = lprf_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((3 * COORD_BITS + lprf_pkg::OUT_FIXED_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
	import lprf_pkg::*;

	// Once reset is seen at a clock edge, the output register is empty at the next one.
	`LPRF_ASSERT_ALWAYS(a_no_beat_in_reset, !arst_n |=> !m_axis_tvalid, "output valid during reset")

	// A stalled result beat keeps its valid and its data.
	`LPRF_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

	// Points are worked on one at a time: an accepted point closes the input.
	`LPRF_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a point is in work")

	// A new result is only written from the decision step, with input closed.
	`LPRF_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without a point in work")

endmodule

bind lidar_point_range_filter_top lprf_checker #(.COORD_BITS(COORD_BITS)) u_lprf_checker (.*);
